// ===== rtl/swd_bit_sequencer_defines.svh =====
// assertion macros shared by the swd sequencer checker
// expects clk_i and rst_ni in the scope where a macro is used
`ifndef SWD_BIT_SEQUENCER_DEFINES_SVH
`define SWD_BIT_SEQUENCER_DEFINES_SVH

// combinational implication checked at each edge
`define SWD_ASSERT_IMPL(label, cond, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |-> (prop)) \
    else $error(msg);

// non-overlapping implication, checked at each edge
`define SWD_ASSERT_NEXT(label, cond, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |=> (prop)) \
    else $error(msg);

`endif

// ===== rtl/swd_seq_pkg.sv =====
// shared types and constants of the swd bit sequencer
// no dependencies
`timescale 1ns / 1ps

package swd_seq_pkg;

  // longest data run a command may ask for
  localparam int unsigned MaxBits   = 32;
  localparam int unsigned LimitBits = (MaxBits < 32) ? MaxBits : 32;
  localparam logic [5:0]  NLimit    = 6'(LimitBits);

  // command queue between front and back
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QPtrW      = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned QCntW      = $clog2(QueueDepth + 1);

  // operation codes
  localparam logic [1:0] OpRead     = 2'd0;
  localparam logic [1:0] OpReadPar  = 2'd1;
  localparam logic [1:0] OpWrite    = 2'd2;
  localparam logic [1:0] OpWritePar = 2'd3;

  // classified command as queued for the back end
  typedef struct packed {
    logic        turn;      // turnaround pulse first
    logic        is_read;
    logic        with_par;
    logic [5:0]  nbits;     // effective data bit count, 1..LimitBits
    logic [31:0] wdata;
    logic        wpar;      // even parity over the whole write word
    logic [31:0] rdata;     // masked received bits
    logic        perr;      // received bits plus parity bit odd
  } cmd_t;

endpackage

// ===== rtl/swd_seq_front.sv =====
// front end: takes command beats, tracks line direction, classifies
// depends on swd_seq_pkg
`timescale 1ns / 1ps

module swd_seq_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         op_i,
  input  logic [5:0]         bit_count_i,
  input  logic [31:0]        write_data_i,
  input  logic [32:0]        line_samples_i,
  output logic               push_o,
  output swd_seq_pkg::cmd_t  cmd_o,
  input  logic               full_i
);

  logic        line_is_input_q, line_is_input_d;
  logic [5:0]  n_eff;
  logic [32:0] mask;
  logic [31:0] rdata;
  logic        is_read;

  assign in_ready_o = ~full_i;
  assign push_o     = in_valid_i & ~full_i;
  assign is_read    = (op_i == swd_seq_pkg::OpRead) || (op_i == swd_seq_pkg::OpReadPar);

  always_comb begin
    n_eff = bit_count_i;
    if (n_eff == 6'd0) begin
      n_eff = 6'd1;
    end
    if (n_eff > swd_seq_pkg::NLimit) begin
      n_eff = swd_seq_pkg::NLimit;
    end
  end

  assign mask  = (33'd1 << n_eff) - 33'd1;
  assign rdata = line_samples_i[31:0] & mask[31:0];

  always_comb begin
    cmd_o.turn     = (is_read != line_is_input_q);
    cmd_o.is_read  = is_read;
    cmd_o.with_par = (op_i == swd_seq_pkg::OpReadPar) || (op_i == swd_seq_pkg::OpWritePar);
    cmd_o.nbits    = n_eff;
    cmd_o.wdata    = write_data_i;
    cmd_o.wpar     = ^write_data_i;
    cmd_o.rdata    = rdata;
    cmd_o.perr     = (^rdata) ^ line_samples_i[n_eff];
  end

  assign line_is_input_d = push_o ? is_read : line_is_input_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_is_input_q <= 1'b0;
    end else begin
      line_is_input_q <= line_is_input_d;
    end
  end

endmodule

// ===== rtl/swd_seq_fifo.sv =====
// short command queue between front and back end
// depends on swd_seq_pkg
`timescale 1ns / 1ps

module swd_seq_fifo (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  swd_seq_pkg::cmd_t  wr_cmd_i,
  output logic               full_o,
  input  logic               pop_i,
  output logic               valid_o,
  output swd_seq_pkg::cmd_t  rd_cmd_o
);

  localparam int unsigned Depth = swd_seq_pkg::QueueDepth;
  localparam int unsigned PtrW  = swd_seq_pkg::QPtrW;
  localparam int unsigned CntW  = swd_seq_pkg::QCntW;

  swd_seq_pkg::cmd_t entry_q [Depth];
  logic [PtrW-1:0]   wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]   count_q, count_d;
  logic              do_push, do_pop;

  assign full_o   = (count_q == CntW'(Depth));
  assign valid_o  = (count_q != '0);
  assign do_push  = push_i & ~full_o;
  assign do_pop   = pop_i & valid_o;
  assign rd_cmd_o = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= wr_cmd_i;
    end
  end

endmodule

// ===== rtl/swd_seq_back.sv =====
// back end: plays one queued command out as swclk pulses, two phases each
// depends on swd_seq_pkg
`timescale 1ns / 1ps

module swd_seq_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               q_valid_i,
  input  swd_seq_pkg::cmd_t  q_cmd_i,
  output logic               q_pop_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               level_o,
  output logic               drive_o,
  output logic               turn_o,
  output logic               last_o,
  output logic [31:0]        read_data_o,
  output logic               perr_o
);

  localparam logic StIdle = 1'b0;
  localparam logic StRun  = 1'b1;

  logic        state_q, state_d;
  logic        phase_q, phase_d;
  logic        turn_q, turn_d;
  logic [5:0]  idx_q, idx_d;
  logic [5:0]  nbits_q;
  logic        is_read_q, with_par_q, wpar_q, cmd_perr_q;
  logic [31:0] shift_q, shift_d;
  logic [31:0] cmd_rdata_q;

  logic        ov_q, ov_d;
  logic        lvl_q, lvl_d, drv_q, drv_d, ta_q, ta_d, lst_q, lst_d, pe_q, pe_d;
  logic [31:0] rd_q, rd_d;

  logic gen, data_last;

  assign q_pop_o   = (state_q == StIdle) & q_valid_i;
  assign gen       = (state_q == StRun) & phase_q & (~ov_q | out_ready_i);
  assign data_last = ((idx_q + 6'd1) == nbits_q) & ~with_par_q;

  always_comb begin
    state_d = state_q;
    phase_d = phase_q;
    turn_d  = turn_q;
    idx_d   = idx_q;
    shift_d = shift_q;
    ov_d    = ov_q & ~out_ready_i;
    lvl_d   = lvl_q;
    drv_d   = drv_q;
    ta_d    = ta_q;
    lst_d   = lst_q;
    rd_d    = rd_q;
    pe_d    = pe_q;
    if (q_pop_o) begin
      state_d = StRun;
      phase_d = 1'b0;
      turn_d  = q_cmd_i.turn;
      idx_d   = '0;
      shift_d = q_cmd_i.wdata;
    end else if (state_q == StRun) begin
      // high phase then low phase; the low phase waits for the output slot
      if (!phase_q || gen) begin
        phase_d = ~phase_q;
      end
      if (gen) begin
        ov_d = 1'b1;
        pe_d = 1'b0;
        rd_d = '0;
        ta_d = 1'b0;
        if (turn_q) begin
          turn_d = 1'b0;
          lvl_d  = 1'b0;
          drv_d  = 1'b0;
          ta_d   = 1'b1;
          lst_d  = 1'b0;
        end else if (idx_q < nbits_q) begin
          lvl_d   = ~is_read_q & shift_q[0];
          drv_d   = ~is_read_q;
          lst_d   = data_last;
          rd_d    = (data_last & is_read_q) ? cmd_rdata_q : '0;
          idx_d   = idx_q + 6'd1;
          shift_d = {1'b0, shift_q[31:1]};
          if (data_last) begin
            state_d = StIdle;
          end
        end else begin
          // parity pulse closes the command
          lvl_d   = ~is_read_q & wpar_q;
          drv_d   = ~is_read_q;
          lst_d   = 1'b1;
          rd_d    = is_read_q ? cmd_rdata_q : '0;
          pe_d    = is_read_q & cmd_perr_q;
          state_d = StIdle;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      phase_q <= 1'b0;
      turn_q  <= 1'b0;
      idx_q   <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
      turn_q  <= turn_d;
      idx_q   <= idx_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      nbits_q     <= q_cmd_i.nbits;
      is_read_q   <= q_cmd_i.is_read;
      with_par_q  <= q_cmd_i.with_par;
      wpar_q      <= q_cmd_i.wpar;
      cmd_rdata_q <= q_cmd_i.rdata;
      cmd_perr_q  <= q_cmd_i.perr;
    end
    shift_q <= shift_d;
    lvl_q   <= lvl_d;
    drv_q   <= drv_d;
    ta_q    <= ta_d;
    lst_q   <= lst_d;
    rd_q    <= rd_d;
    pe_q    <= pe_d;
  end

  assign out_valid_o = ov_q;
  assign level_o     = lvl_q;
  assign drive_o     = drv_q;
  assign turn_o      = ta_q;
  assign last_o      = lst_q;
  assign read_data_o = rd_q;
  assign perr_o      = pe_q;

endmodule

// ===== rtl/swd_bit_sequencer.sv =====
// top level of the swd bit sequencer: front end, command queue, back end
// depends on swd_seq_pkg, swd_seq_front, swd_seq_fifo, swd_seq_back
`timescale 1ns / 1ps

// channel   direction  beat
// s_axis    in         one command (op in tuser, counts and data in tdata)
// m_axis    out        one swclk pulse (tlast on the final pulse of a command)
//
// each pulse runs through a high phase and a low phase in the back end sequencer
// once the command is taken from the queue; a command has k pulses,
// k = turnaround + bits + parity, 1..34, and the queue lets up to two commands
// wait meanwhile
// reset clears the line direction to host driving and empties the queue
// a stalled m_axis holds the low phase; s_axis stalls only while the queue is full

module swd_bit_sequencer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [71:0] s_axis_tdata,   // bit_count, write_data, line_samples, zero pad
  input  logic [1:0]  s_axis_tuser,   // op
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // swdio_level, swdio_drive, read_data, parity_error, pad
  output logic        m_axis_tuser,   // turnaround
  output logic        m_axis_tlast
);

  swd_seq_pkg::cmd_t push_cmd, pop_cmd;
  logic              push, full, q_valid, pop;
  logic              level, drive, turn, last, perr;
  logic [31:0]       read_data;

  // classify and track direction
  swd_seq_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (s_axis_tvalid),
    .in_ready_o     (s_axis_tready),
    .op_i           (s_axis_tuser),
    .bit_count_i    (s_axis_tdata[5:0]),
    .write_data_i   (s_axis_tdata[37:6]),
    .line_samples_i (s_axis_tdata[70:38]),
    .push_o         (push),
    .cmd_o          (push_cmd),
    .full_i         (full)
  );

  // decouples command intake from pulse generation
  swd_seq_fifo u_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .wr_cmd_i (push_cmd),
    .full_o   (full),
    .pop_i    (pop),
    .valid_o  (q_valid),
    .rd_cmd_o (pop_cmd)
  );

  // pulse sequencer with registered output
  swd_seq_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_cmd_i     (pop_cmd),
    .q_pop_o     (pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .level_o     (level),
    .drive_o     (drive),
    .turn_o      (turn),
    .last_o      (last),
    .read_data_o (read_data),
    .perr_o      (perr)
  );

  assign m_axis_tdata = {5'd0, perr, read_data, drive, level};
  assign m_axis_tuser = turn;
  assign m_axis_tlast = last;

endmodule

// ===== rtl/swd_seq_checker.sv =====
// port level checks on the swd bit sequencer, bound to the top level
// depends on swd_bit_sequencer_defines.svh and swd_bit_sequencer
`timescale 1ns / 1ps
`include "swd_bit_sequencer_defines.svh"

module swd_seq_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [39:0] m_axis_tdata,
  input logic        m_axis_tuser,
  input logic        m_axis_tlast
);

  // turnaround pulse floats the line and never ends a command
  `SWD_ASSERT_IMPL(a_turn_floats, m_axis_tvalid && m_axis_tuser,
                   !m_axis_tdata[1] && !m_axis_tdata[0] && !m_axis_tlast,
                   "turnaround beat drives line or ends command")

  // a high level only while the host drives
  `SWD_ASSERT_IMPL(a_level_driven, m_axis_tvalid && m_axis_tdata[0], m_axis_tdata[1],
                   "level high while floating")

  // parity error only on the last pulse of a read
  `SWD_ASSERT_IMPL(a_perr_on_last, m_axis_tvalid && m_axis_tdata[34],
                   m_axis_tlast && !m_axis_tdata[1], "parity error outside read end")

  // a stalled beat holds
  `SWD_ASSERT_NEXT(a_hold_on_stall, m_axis_tvalid && !m_axis_tready,
                   m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast),
                   "stalled beat changed")

endmodule

bind swd_bit_sequencer swd_seq_checker u_swd_seq_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);

// ===== tb/sv/tb_swd_bit_sequencer.sv =====
// self-checking testbench of swd_bit_sequencer: random and directed commands in,
// every swclk pulse checked against a predictor kept in step with accepted commands
// depends on swd_seq_pkg and the swd_bit_sequencer rtl
`timescale 1ns / 1ps

module tb_swd_bit_sequencer;

  // one command as offered on s_axis
  typedef struct {
    logic [1:0]  op;
    logic [5:0]  nbits;
    logic [31:0] wdata;
    logic [32:0] samples;
  } swd_cmd_t;

  // one swclk pulse as expected on m_axis
  typedef struct {
    logic        level;
    logic        drive;
    logic        turn;
    logic        fin;
    logic [31:0] rdata;
    logic        perr;
  } swd_pulse_t;

  localparam int NumRandom    = 93;
  localparam int StallLimit   = 3000;  // cycles with no beat on either side
  localparam int HoldCycles   = 400;   // long receiver hold-off
  localparam int DrainCycles  = 80;    // a bit more than one full command

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [71:0] s_axis_tdata = '0;   // bit_count, write_data, line_samples, zero pad
  logic [1:0]  s_axis_tuser = '0;   // op
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;        // swdio_level, swdio_drive, read_data, parity_error, pad
  logic        m_axis_tuser;        // turnaround
  logic        m_axis_tlast;

  swd_bit_sequencer dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  swd_cmd_t   cmd_q[$];     // commands not yet offered
  swd_pulse_t pulse_q[$];   // pulses owed by accepted commands
  logic       line_in = 1'b0;  // predicted line direction, 1 = turned to target
  int         total_cmds = 0;
  int         accepted_cmds = 0;
  int         mismatches = 0;
  int         stall_cnt = 0;
  int         hold_left = 0;
  logic       hold_done = 1'b0;
  logic       cmd_taken = 1'b0;  // a command beat happened at the last rising edge

  // idle mix follows progress: receiver-heavy idling, then sender-heavy, then none
  function automatic int phase_of(int done);
    if (done < total_cmds / 3) begin
      return 0;
    end
    if (done < (2 * total_cmds) / 3) begin
      return 1;
    end
    return 2;
  endfunction

  // expected pulse train of one command; updates the predicted line direction
  task automatic push_line_pulses(input logic [1:0] op, input logic [5:0] cnt,
                                  input logic [31:0] wd, input logic [32:0] smp);
    int          n;
    logic        rd;
    logic        par;
    logic [31:0] rmask;
    logic [31:0] rdata;
    logic        perr;
    swd_pulse_t  p;
    n = cnt;
    if (n == 0) begin
      n = 1;  // zero count still gives one data bit
    end
    if (n > swd_seq_pkg::LimitBits) begin
      n = swd_seq_pkg::LimitBits;  // oversized counts saturate
    end
    rd  = (op == swd_seq_pkg::OpRead) || (op == swd_seq_pkg::OpReadPar);
    par = (op == swd_seq_pkg::OpReadPar) || (op == swd_seq_pkg::OpWritePar);
    // turnaround only on a direction change, line floating
    if (rd != line_in) begin
      line_in = rd;
      p = '{level: 1'b0, drive: 1'b0, turn: 1'b1, fin: 1'b0, rdata: '0, perr: 1'b0};
      pulse_q.push_back(p);
    end
    if (rd) begin
      rmask = (n >= 32) ? 32'hffff_ffff : ((32'h1 << n) - 32'h1);
      rdata = smp[31:0] & rmask;
      perr  = (^rdata) ^ smp[n];
      for (int i = 0; i < n; i++) begin
        p.level = 1'b0;
        p.drive = 1'b0;
        p.turn  = 1'b0;
        p.fin   = (i == n - 1) && !par;
        p.rdata = p.fin ? rdata : '0;
        p.perr  = 1'b0;
        pulse_q.push_back(p);
      end
      if (par) begin
        p = '{level: 1'b0, drive: 1'b0, turn: 1'b0, fin: 1'b1, rdata: rdata, perr: perr};
        pulse_q.push_back(p);
      end
    end else begin
      for (int i = 0; i < n; i++) begin
        p.level = wd[i];
        p.drive = 1'b1;
        p.turn  = 1'b0;
        p.fin   = (i == n - 1) && !par;
        p.rdata = '0;
        p.perr  = 1'b0;
        pulse_q.push_back(p);
      end
      if (par) begin
        // parity spans the whole word even for short writes
        p = '{level: ^wd, drive: 1'b1, turn: 1'b0, fin: 1'b1, rdata: '0, perr: 1'b0};
        pulse_q.push_back(p);
      end
    end
  endtask

  task automatic add_cmd(input logic [1:0] op, input logic [5:0] n,
                         input logic [31:0] wd, input logic [32:0] smp);
    swd_cmd_t c;
    c = '{op: op, nbits: n, wdata: wd, samples: smp};
    cmd_q.push_back(c);
  endtask

  // clock
  initial begin
    forever begin
      #5 clk_i = ~clk_i;
    end
  end

  // command driver: changes on the falling edge, holds a beat until taken
  always @(negedge clk_i) begin
    int       idle_pct;
    swd_cmd_t c;
    if (rst_ni && (!s_axis_tvalid || cmd_taken)) begin
      idle_pct = (phase_of(accepted_cmds) == 0) ? 32 :
                 (phase_of(accepted_cmds) == 1) ? 88 : 0;
      if (cmd_q.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
        c = cmd_q.pop_front();
        s_axis_tuser  <= c.op;
        s_axis_tdata  <= {1'b0, c.samples, c.wdata, c.nbits};
        s_axis_tvalid <= 1'b1;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // pulse receiver: random idling plus one long hold-off once the fast phase starts
  always @(negedge clk_i) begin
    int idle_pct;
    if (rst_ni) begin
      idle_pct = (phase_of(accepted_cmds) == 0) ? 88 :
                 (phase_of(accepted_cmds) == 1) ? 32 : 0;
      if (hold_left > 0) begin
        hold_left     <= hold_left - 1;
        m_axis_tready <= 1'b0;
      end else if (!hold_done && phase_of(accepted_cmds) == 2) begin
        // sender keeps offering while we stall, so the queue fills and s_axis backs up
        hold_left     <= HoldCycles;
        hold_done     <= 1'b1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(0, 99) >= idle_pct);
      end
    end
  end

  // monitor: checks each pulse beat, then records the command beat of the same edge
  always @(posedge clk_i) begin
    swd_pulse_t exp_p;
    swd_pulse_t got;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.level = m_axis_tdata[0];
        got.drive = m_axis_tdata[1];
        got.rdata = m_axis_tdata[33:2];
        got.perr  = m_axis_tdata[34];
        got.turn  = m_axis_tuser;
        got.fin   = m_axis_tlast;
        if (pulse_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("[%0t] pulse with none pending: lvl=%b drv=%b ta=%b last=%b rd=%h pe=%b",
                     $time, got.level, got.drive, got.turn, got.fin, got.rdata, got.perr);
          end
        end else begin
          exp_p = pulse_q.pop_front();
          if (got.level !== exp_p.level || got.drive !== exp_p.drive ||
              got.turn !== exp_p.turn || got.fin !== exp_p.fin ||
              got.rdata !== exp_p.rdata || got.perr !== exp_p.perr) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("[%0t] pulse mismatch exp lvl=%b drv=%b ta=%b last=%b rd=%h pe=%b",
                       $time, exp_p.level, exp_p.drive, exp_p.turn, exp_p.fin,
                       exp_p.rdata, exp_p.perr);
              $display("[%0t]                got lvl=%b drv=%b ta=%b last=%b rd=%h pe=%b",
                       $time, got.level, got.drive, got.turn, got.fin, got.rdata, got.perr);
            end
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        push_line_pulses(s_axis_tuser, s_axis_tdata[5:0], s_axis_tdata[37:6],
                         s_axis_tdata[70:38]);
        accepted_cmds++;
      end
      cmd_taken <= s_axis_tvalid && s_axis_tready;
    end
  end

  // watchdog: no beat on either side for too long ends the run
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        stall_cnt <= 0;
      end else if (stall_cnt >= StallLimit) begin
        $display("timeout after %0d idle cycles", stall_cnt);
        $display("simulation failed");
        $finish;
      end else begin
        stall_cnt <= stall_cnt + 1;
      end
    end
  end

  // stimulus and end of run
  initial begin
    logic [1:0]  op;
    logic [5:0]  n;
    logic [32:0] smp;
    // directed: extremes, every op, both turnaround directions, zero and oversized counts
    add_cmd(swd_seq_pkg::OpWrite,    6'd8,  32'h0000_00a5, 33'h0);  // host already driving
    add_cmd(swd_seq_pkg::OpWritePar, 6'd32, 32'hffff_ffff, 33'h0);
    add_cmd(swd_seq_pkg::OpWritePar, 6'd4,  32'h0000_0010, 33'h0);  // parity from unsent bits
    add_cmd(swd_seq_pkg::OpRead,     6'd1,  32'h0, 33'h1);            // turn to target
    add_cmd(swd_seq_pkg::OpReadPar,  6'd32, 32'h0, 33'h1_ffff_ffff);  // parity error
    add_cmd(swd_seq_pkg::OpReadPar,  6'd32, 32'h0, 33'h0_ffff_ffff);  // parity good
    add_cmd(swd_seq_pkg::OpReadPar,  6'd8,  32'h0, 33'h0_0000_01ff);
    add_cmd(swd_seq_pkg::OpRead,     6'd0,  32'h0, 33'h0);            // zero count
    add_cmd(swd_seq_pkg::OpReadPar,  6'd0,  32'h0, 33'h0_0000_0003);
    add_cmd(swd_seq_pkg::OpRead,     6'd63, 32'h0, 33'h1_ffff_ffff);  // saturated
    add_cmd(swd_seq_pkg::OpWrite,    6'd0,  32'h0000_0001, 33'h0);  // turn back to host
    add_cmd(swd_seq_pkg::OpWrite,    6'd63, 32'hdead_beef, 33'h0);
    add_cmd(swd_seq_pkg::OpWritePar, 6'd33, 32'h0, 33'h0);
    add_cmd(swd_seq_pkg::OpRead,     6'd32, 32'h0, 33'h1_2345_6789);
    add_cmd(swd_seq_pkg::OpReadPar,  6'd40, 32'h0, 33'h1_0000_0000);
    add_cmd(swd_seq_pkg::OpWrite,    6'd32, 32'h0, 33'h0);
    add_cmd(swd_seq_pkg::OpWritePar, 6'd1,  32'h8000_0001, 33'h1_ffff_ffff);
    add_cmd(swd_seq_pkg::OpReadPar,  6'd5,  32'hffff_ffff, 33'h0_0000_0035);
    // random: mostly legal counts, some zero or oversized, any op in any order
    for (int i = 0; i < NumRandom; i++) begin
      op = 2'($urandom_range(0, 3));
      case ($urandom_range(0, 9))
        0: begin
          n = 6'($urandom_range(0, 63));
        end
        1: begin
          n = 6'd32;
        end
        2, 3: begin
          n = 6'($urandom_range(1, 32));
        end
        default: begin
          n = 6'($urandom_range(1, 12));
        end
      endcase
      smp = {1'($urandom_range(0, 1)), 32'($urandom())};
      add_cmd(op, n, 32'($urandom()), smp);
    end
    total_cmds = cmd_q.size();

    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (cmd_q.size() != 0 || s_axis_tvalid || pulse_q.size() != 0) begin
      @(posedge clk_i);
    end
    // catch any stray pulse after the last expected one
    repeat (DrainCycles) @(posedge clk_i);
    if (pulse_q.size() != 0) begin
      mismatches++;
      $display("%0d expected pulses never arrived", pulse_q.size());
    end
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
